>>> src/obbc_pkg.sv
// ----------------------------------------------------------------------------
// obbc_pkg
// Shared constants, register codes and types for the box frustum cull test.
// ----------------------------------------------------------------------------
package obbc_pkg;

  // default coordinate width, signed Q.8
  localparam int unsigned COORD_WIDTH_DEF = 24;

  // plane register layout
  localparam int unsigned NUM_PLANES   = 6;
  localparam int unsigned NUM_AXES     = 3;
  localparam int unsigned NORMAL_W     = 13;  // signed Q1.11
  localparam int unsigned DIST_W       = 24;  // signed Q15.8
  localparam int unsigned DIST_LSB     = 39;
  localparam int unsigned FRAC_ALIGN   = 11;  // Q.8 -> Q.19
  localparam int unsigned PLANE_W      = 63;  // bit 63 is never used

  // configuration port
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CULL_EN      = 3'd0,
    REG_PLANE_LEFT   = 3'd1,
    REG_PLANE_RIGHT  = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_BOTTOM = 3'd4,
    REG_PLANE_NEAR   = 3'd5,
    REG_PLANE_FAR    = 3'd6
  } obbc_reg_e;

  // control handed from cell to cell
  typedef struct packed {
    logic valid;
    logic ok;
  } obbc_ctl_t;

  // accumulator width: three products of 13 x (cw+2) bits plus the aligned distance
  function automatic int unsigned acc_width(input int unsigned cw);
    int unsigned a;
    a = cw + 17;
    if (a < DIST_W + FRAC_ALIGN + 2) begin
      a = DIST_W + FRAC_ALIGN + 2;
    end
    return a;
  endfunction

endpackage

>>> src/obbc_extent.sv
// ----------------------------------------------------------------------------
// obbc_extent
// Head stage: world extents per axis from the three scaled half-axes.
// ----------------------------------------------------------------------------
module obbc_extent import obbc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int unsigned EXT_W = COORD_WIDTH + 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [3*NUM_AXES-1:0][COORD_WIDTH-1:0] axis_i,
  input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   ctr_i,
  output obbc_ctl_t                              ctl_o,
  output logic [NUM_AXES-1:0][EXT_W-1:0]         ext_o,
  output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   ctr_o
);

  logic [3*NUM_AXES-1:0][COORD_WIDTH-1:0] mag;
  logic [NUM_AXES-1:0][EXT_W-1:0]         ext_d;
  obbc_ctl_t                              ctl_q;
  logic [NUM_AXES-1:0][EXT_W-1:0]         ext_q;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   ctr_q;

  // absolute value of every half-axis component
  always_comb begin
    for (int j = 0; j < 3 * NUM_AXES; j++) begin
      mag[j] = axis_i[j][COORD_WIDTH-1] ? COORD_WIDTH'(-axis_i[j]) : axis_i[j];
    end
  end

  // extent k sums component k of right, up and forward
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      ext_d[k] = EXT_W'(mag[k]) + EXT_W'(mag[NUM_AXES + k]) + EXT_W'(mag[2 * NUM_AXES + k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q.valid <= valid_i;
      ctl_q.ok    <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ext_q <= ext_d;
      ctr_q <= ctr_i;
    end
  end

  assign ctl_o = ctl_q;
  assign ext_o = ext_q;
  assign ctr_o = ctr_q;

endmodule

>>> src/obbc_cell.sv
// ----------------------------------------------------------------------------
// obbc_cell
// One plane, one axis: adds n*(c +/- ext) to the running plane sum.
// ----------------------------------------------------------------------------
module obbc_cell import obbc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned AXIS        = 0,
  localparam int unsigned EXT_W = COORD_WIDTH + 1,
  localparam int unsigned ACC_W = acc_width(COORD_WIDTH)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic [PLANE_W-1:0]                   plane_i,
  input  obbc_ctl_t                            ctl_i,
  input  logic [NUM_AXES-1:0][EXT_W-1:0]       ext_i,
  input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] ctr_i,
  input  logic signed [ACC_W-1:0]              acc_i,
  output obbc_ctl_t                            ctl_o,
  output logic [NUM_AXES-1:0][EXT_W-1:0]       ext_o,
  output logic [NUM_AXES-1:0][COORD_WIDTH-1:0] ctr_o,
  output logic signed [ACC_W-1:0]              acc_o
);

  localparam int unsigned V_W = COORD_WIDTH + 2;
  localparam int unsigned P_W = V_W + NORMAL_W;

  logic signed [NORMAL_W-1:0] norm;
  logic signed [DIST_W-1:0]   dist_v;
  logic signed [V_W-1:0]      ctr_s;
  logic signed [V_W-1:0]      ext_s;
  logic signed [V_W-1:0]      v;
  logic signed [P_W-1:0]      prod;
  logic signed [ACC_W-1:0]    dist_al;
  logic signed [ACC_W-1:0]    acc_base;
  logic signed [ACC_W-1:0]    acc_d;
  logic                       ok_d;
  obbc_ctl_t                  ctl_q;
  logic [NUM_AXES-1:0][EXT_W-1:0]       ext_q;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] ctr_q;
  logic signed [ACC_W-1:0]    acc_q;

  // plane fields for this axis
  assign norm   = $signed(plane_i[AXIS*NORMAL_W +: NORMAL_W]);
  assign dist_v = $signed(plane_i[DIST_LSB +: DIST_W]);

  // |n|*ext + n*c folded into one product: n*(c + sign(n)*ext)
  assign ctr_s = V_W'($signed(ctr_i[AXIS]));
  assign ext_s = $signed(V_W'(ext_i[AXIS]));
  assign v     = norm[NORMAL_W-1] ? (ctr_s - ext_s) : (ctr_s + ext_s);
  assign prod  = P_W'(norm) * P_W'(v);

  // first axis seeds the sum with -d, aligned to Q.19
  assign dist_al  = ACC_W'(dist_v) <<< FRAC_ALIGN;
  assign acc_base = (AXIS == 0) ? -dist_al : acc_i;
  assign acc_d    = acc_base + ACC_W'(prod);

  // last axis: plane passes when s + r >= 0
  assign ok_d = (AXIS == NUM_AXES - 1) ? (ctl_i.ok & ~acc_d[ACC_W-1]) : ctl_i.ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q.valid <= ctl_i.valid;
      ctl_q.ok    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ext_q <= ext_i;
      ctr_q <= ctr_i;
      acc_q <= acc_d;
    end
  end

  assign ctl_o = ctl_q;
  assign ext_o = ext_q;
  assign ctr_o = ctr_q;
  assign acc_o = acc_q;

endmodule

>>> src/obbc_cfg.sv
// ----------------------------------------------------------------------------
// obbc_cfg
// Register file: cull enable and the six packed frustum planes.
// ----------------------------------------------------------------------------
module obbc_cfg import obbc_pkg::*; (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_i,
  input  logic [CFG_IDX_W-1:0]                idx_i,
  input  logic [CFG_DATA_W-1:0]               data_i,
  output logic                                cull_en_o,
  output logic [NUM_PLANES-1:0][PLANE_W-1:0]  plane_o
);

  logic                               cull_en_q;
  logic [NUM_PLANES-1:0][PLANE_W-1:0] plane_q;

  // register write decode; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cull_en_q <= 1'b0;
      plane_q   <= '0;
    end else if (wr_i) begin
      unique case (obbc_reg_e'(idx_i))
        REG_CULL_EN:      cull_en_q  <= data_i[0];
        REG_PLANE_LEFT:   plane_q[0] <= data_i[PLANE_W-1:0];
        REG_PLANE_RIGHT:  plane_q[1] <= data_i[PLANE_W-1:0];
        REG_PLANE_TOP:    plane_q[2] <= data_i[PLANE_W-1:0];
        REG_PLANE_BOTTOM: plane_q[3] <= data_i[PLANE_W-1:0];
        REG_PLANE_NEAR:   plane_q[4] <= data_i[PLANE_W-1:0];
        REG_PLANE_FAR:    plane_q[5] <= data_i[PLANE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cull_en_o = cull_en_q;
  assign plane_o   = plane_q;

endmodule

>>> src/obbc_frustum_cull_test_dummy_never.sv
// ----------------------------------------------------------------------------
// obbc_out
// Output register: holds the result item until it is taken.
// ----------------------------------------------------------------------------
module obbc_out import obbc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      cull_en_i,
  input  obbc_ctl_t ctl_i,
  output logic      valid_o,
  output logic      in_view_o
);

  logic valid_q;
  logic in_view_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  // culling off reports every box in view
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_view_q <= ~cull_en_i | ctl_i.ok;
    end
  end

  assign valid_o   = valid_q;
  assign in_view_o = in_view_q;

endmodule

>>> src/obb_frustum_cull_test.sv
// ----------------------------------------------------------------------------
// obb_frustum_cull_test
// Oriented box against six frustum planes, one box per clock unless the output is held.
// ----------------------------------------------------------------------------
// A box enters at most once per cycle and its in_view result ends up in the
// output register after it has passed every stage: one stage forms the
// world extents, then a row of 18 cells (six planes times three axes) each
// adds one term n*(c +/- ext) to the running plane sum, the last cell of
// each plane checks the sign, and a final register holds the item. Each
// cell holds one multiplier of 13 by COORD_WIDTH+2 bits, which sets the
// cycle. The whole row advances together and stops only while the output
// register holds an item that is not taken.
// Configuration must be written only while no box is in flight.
// ----------------------------------------------------------------------------
module obb_frustum_cull_test import obbc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // box items
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COORD_WIDTH-1:0] axis_r_x_i,
  input  logic [COORD_WIDTH-1:0] axis_r_y_i,
  input  logic [COORD_WIDTH-1:0] axis_r_z_i,
  input  logic [COORD_WIDTH-1:0] axis_u_x_i,
  input  logic [COORD_WIDTH-1:0] axis_u_y_i,
  input  logic [COORD_WIDTH-1:0] axis_u_z_i,
  input  logic [COORD_WIDTH-1:0] axis_f_x_i,
  input  logic [COORD_WIDTH-1:0] axis_f_y_i,
  input  logic [COORD_WIDTH-1:0] axis_f_z_i,
  input  logic [COORD_WIDTH-1:0] center_x_i,
  input  logic [COORD_WIDTH-1:0] center_y_i,
  input  logic [COORD_WIDTH-1:0] center_z_i,
  // result items
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   in_view_o
);

  localparam int unsigned EXT_W     = COORD_WIDTH + 1;
  localparam int unsigned ACC_W     = acc_width(COORD_WIDTH);
  localparam int unsigned NUM_CELLS = NUM_PLANES * NUM_AXES;

  logic                                   en;
  logic                                   cull_en;
  logic [NUM_PLANES-1:0][PLANE_W-1:0]     plane;
  logic [3*NUM_AXES-1:0][COORD_WIDTH-1:0] axis_vec;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   ctr_vec;

  obbc_ctl_t                            ctl_chain [NUM_CELLS+1];
  logic [NUM_AXES-1:0][EXT_W-1:0]       ext_chain [NUM_CELLS+1];
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] ctr_chain [NUM_CELLS+1];
  logic signed [ACC_W-1:0]              acc_chain [NUM_CELLS+1];

  // the row moves whenever the output register is free or being emptied
  assign en          = ~out_valid_o | out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  obbc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cfg_valid_i),
    .idx_i     (cfg_index_i),
    .data_i    (cfg_data_i),
    .cull_en_o (cull_en),
    .plane_o   (plane)
  );

  // half-axes ordered right, up, forward; x, y, z within each
  assign axis_vec = {axis_f_z_i, axis_f_y_i, axis_f_x_i,
                     axis_u_z_i, axis_u_y_i, axis_u_x_i,
                     axis_r_z_i, axis_r_y_i, axis_r_x_i};
  assign ctr_vec  = {center_z_i, center_y_i, center_x_i};

  obbc_extent #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_extent (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .axis_i  (axis_vec),
    .ctr_i   (ctr_vec),
    .ctl_o   (ctl_chain[0]),
    .ext_o   (ext_chain[0]),
    .ctr_o   (ctr_chain[0])
  );

  // first cell of each plane reseeds the sum, so this is never used
  assign acc_chain[0] = '0;

  // row of cells: plane-major, axis-minor
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    obbc_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .AXIS        (i % NUM_AXES)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .plane_i (plane[i / NUM_AXES]),
      .ctl_i   (ctl_chain[i]),
      .ext_i   (ext_chain[i]),
      .ctr_i   (ctr_chain[i]),
      .acc_i   (acc_chain[i]),
      .ctl_o   (ctl_chain[i+1]),
      .ext_o   (ext_chain[i+1]),
      .ctr_o   (ctr_chain[i+1]),
      .acc_o   (acc_chain[i+1])
    );
  end

  obbc_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .cull_en_i (cull_en),
    .ctl_i     (ctl_chain[NUM_CELLS]),
    .valid_o   (out_valid_o),
    .in_view_o (in_view_o)
  );

endmodule

>>> sim/obb_frustum_cull_test_tb.sv
// ----------------------------------------------------------------------------
// obb_frustum_cull_test_tb
// Checks the box frustum cull test against a cycle-free model of its maths.
// A queue of boxes feeds a valid/ready driver with random gaps. A monitor
// with random back-pressure compares every in_view result with the value the
// model predicted when the box was taken. Plane and enable registers change
// only between phases, once the pipe is empty.
// ----------------------------------------------------------------------------
module obb_frustum_cull_test_tb;
  import obbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW         = COORD_WIDTH_DEF;
  localparam int unsigned PIPE_DEPTH = 24;     // pipe depth plus margin
  localparam int unsigned MAX_IDLE   = 17;
  localparam int unsigned RAND_ITEMS = 1900;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // index past the list

  typedef logic signed [CW-1:0] coord_t;

  // axis[a][k]: a = right/up/forward, k = x/y/z
  typedef struct packed {
    coord_t [2:0][2:0] axis;
    coord_t [2:0]      centre;
  } box_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [CW-1:0]         axis_r_x_i  = '0;
  logic [CW-1:0]         axis_r_y_i  = '0;
  logic [CW-1:0]         axis_r_z_i  = '0;
  logic [CW-1:0]         axis_u_x_i  = '0;
  logic [CW-1:0]         axis_u_y_i  = '0;
  logic [CW-1:0]         axis_u_z_i  = '0;
  logic [CW-1:0]         axis_f_x_i  = '0;
  logic [CW-1:0]         axis_f_y_i  = '0;
  logic [CW-1:0]         axis_f_z_i  = '0;
  logic [CW-1:0]         center_x_i  = '0;
  logic [CW-1:0]         center_y_i  = '0;
  logic [CW-1:0]         center_z_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  in_view_o;

  // shadow of the configuration registers
  bit                    cull_on;
  logic [CFG_DATA_W-1:0] plane_reg [NUM_PLANES];

  box_t box_q [$];         // boxes waiting to be sent
  bit   in_view_q [$];     // predicted in_view, oldest first
  int   err_cnt;

  obb_frustum_cull_test #(
    .COORD_WIDTH (CW)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .axis_r_x_i  (axis_r_x_i),
    .axis_r_y_i  (axis_r_y_i),
    .axis_r_z_i  (axis_r_z_i),
    .axis_u_x_i  (axis_u_x_i),
    .axis_u_y_i  (axis_u_y_i),
    .axis_u_z_i  (axis_u_z_i),
    .axis_f_x_i  (axis_f_x_i),
    .axis_f_y_i  (axis_f_y_i),
    .axis_f_z_i  (axis_f_z_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .center_z_i  (center_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .in_view_o   (in_view_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Exact in_view of one box under the current shadow registers.
  // Extents and centre are Q.8, normals Q.11, so distance is aligned to Q.19.
  function automatic bit box_in_view(box_t b);
    longint                      ext [3];
    longint                      cen [3];
    longint                      n, r, s, dist_l;
    coord_t                      v;
    logic signed [NORMAL_W-1:0]  nrm;
    logic signed [DIST_W-1:0]    dst;
    bit                          ok;
    ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      ext[k] = 0;
      for (int a = 0; a < 3; a++) begin
        v = b.axis[a][k];
        ext[k] += (v < 0) ? -longint'(v) : longint'(v);
      end
      v = b.centre[k];
      cen[k] = v;
    end
    if (!cull_on) return 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      r = 0;
      s = 0;
      for (int k = 0; k < 3; k++) begin
        nrm = plane_reg[p][k*NORMAL_W +: NORMAL_W];
        n = nrm;
        r += ext[k] * ((n < 0) ? -n : n);
        s += n * cen[k];
      end
      dst = plane_reg[p][DIST_LSB +: DIST_W];
      dist_l = dst;
      s -= dist_l * (longint'(1) << FRAC_ALIGN);
      if (s < -r) ok = 1'b0;
    end
    return ok;
  endfunction

  // Driver: random idle gap after each box, with calm stretches
  box_t        cur_box;
  int unsigned send_gap;
  bit          send_calm;

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_view_q.push_back(box_in_view(cur_box));
    end
    if (!in_valid_i || in_ready_o) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (rst_ni && box_q.size() > 0) begin
        cur_box = box_q.pop_front();
        axis_r_x_i <= cur_box.axis[0][0];
        axis_r_y_i <= cur_box.axis[0][1];
        axis_r_z_i <= cur_box.axis[0][2];
        axis_u_x_i <= cur_box.axis[1][0];
        axis_u_y_i <= cur_box.axis[1][1];
        axis_u_z_i <= cur_box.axis[1][2];
        axis_f_x_i <= cur_box.axis[2][0];
        axis_f_y_i <= cur_box.axis[2][1];
        axis_f_z_i <= cur_box.axis[2][2];
        center_x_i <= cur_box.centre[0];
        center_y_i <= cur_box.centre[1];
        center_z_i <= cur_box.centre[2];
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each result, then stall at random before taking the next
  int unsigned take_stall;
  bit          take_calm;
  bit          want;

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (in_view_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual in_view=%b",
                 $time, in_view_o);
        err_cnt++;
      end else begin
        want = in_view_q.pop_front();
        if (in_view_o !== want) begin
          $display("%0t: in_view expected %b actual %b", $time, want, in_view_o);
          err_cnt++;
        end
      end
      if ($urandom_range(0, 31) == 0) take_calm = !take_calm;
      take_stall = take_calm ? 0 : $urandom_range(0, MAX_IDLE);
    end
    if (take_stall > 0) begin
      take_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  // Register write; valid stays high for a following write, see cfg_stop
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CULL_EN: cull_on = data[0];
      REG_PLANE_LEFT, REG_PLANE_RIGHT, REG_PLANE_TOP,
      REG_PLANE_BOTTOM, REG_PLANE_NEAR, REG_PLANE_FAR:
        plane_reg[idx - REG_PLANE_LEFT] = data;
      default: ;  // ignored by the block
    endcase
  endtask

  task automatic cfg_stop();
    cfg_valid_i <= 1'b0;
  endtask

  // Block until every box has gone through and the pipe is empty;
  // looked at on the falling edge, once the driver's updates have settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (box_q.size() != 0 || in_valid_i || in_view_q.size() != 0);
    repeat (PIPE_DEPTH) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pack_plane(bit top, int nx, int ny,
                                                       int nz, int d_val);
    logic [CFG_DATA_W-1:0] p;
    p = '0;
    p[0*NORMAL_W +: NORMAL_W] = nx[NORMAL_W-1:0];
    p[1*NORMAL_W +: NORMAL_W] = ny[NORMAL_W-1:0];
    p[2*NORMAL_W +: NORMAL_W] = nz[NORMAL_W-1:0];
    p[DIST_LSB +: DIST_W]     = d_val[DIST_W-1:0];
    p[CFG_DATA_W-1]           = top;
    return p;
  endfunction

  // Signed value in [-2^bits, 2^bits), or any pattern at full width
  function automatic coord_t rnd_coord(int unsigned bits);
    logic [31:0] r;
    longint      v;
    r = $urandom;
    if (bits >= CW - 1) return r[CW-1:0];
    v = longint'($urandom_range(0, (32'd1 << (bits + 1)) - 1)) - (longint'(1) << bits);
    return v[CW-1:0];
  endfunction

  function automatic box_t fill_box(coord_t ax, coord_t cn);
    box_t b;
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) b.axis[a][k] = ax;
      b.centre[a] = cn;
    end
    return b;
  endfunction

  // Box of a random size class; one in eight uses full-range patterns
  function automatic box_t rnd_box();
    box_t        b;
    int unsigned sz;
    int unsigned cs;
    sz = $urandom_range(0, CW - 1);
    cs = $urandom_range(0, CW - 1);
    if ($urandom_range(0, 7) == 0) begin
      sz = CW - 1;
      cs = CW - 1;
    end
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) b.axis[a][k] = rnd_coord(sz);
      b.centre[a] = rnd_coord(cs);
    end
    return b;
  endfunction

  // Plane with random normal and distance; about a third are left empty
  function automatic logic [CFG_DATA_W-1:0] rnd_plane();
    logic [CFG_DATA_W-1:0] p;
    p = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0) begin
      p[CFG_DATA_W-2:0] = '0;
    end else begin
      p[DIST_LSB +: DIST_W] = rnd_coord($urandom_range(0, CW - 1));
    end
    return p;
  endfunction

  // Stimulus and run control
  initial begin
    box_t             b;
    int unsigned      sent;
    int unsigned      n;
    logic [CFG_DATA_W-1:0] en;

    cull_on = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) plane_reg[p] = '0;
    err_cnt = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state: culling off, every box in view
    box_q.push_back(fill_box(0, 0));
    box_q.push_back(fill_box(coord_t'(8388607), coord_t'(8388607)));
    box_q.push_back(fill_box(coord_t'(-8388608), coord_t'(-8388608)));
    box_q.push_back(fill_box(coord_t'(8388607), coord_t'(-8388608)));
    wait_idle();

    // enable with bit 0 clear but upper bits set: still off
    cfg_write(REG_CULL_EN, 64'hFFFF_FFFF_FFFF_FFFE);
    cfg_stop();
    box_q.push_back(fill_box(coord_t'(-8388608), coord_t'(-8388608)));
    wait_idle();

    // culling on with all-zero planes: everything passes
    cfg_write(REG_CULL_EN, 64'h8000_0000_0000_0001);
    cfg_stop();
    box_q.push_back(fill_box(coord_t'(-8388608), coord_t'(-8388608)));
    box_q.push_back(fill_box(coord_t'(8388607), coord_t'(8388607)));
    wait_idle();

    // left plane x >= 0 (normal 1.0), unused top bit set; box just touching
    cfg_write(REG_PLANE_LEFT, pack_plane(1'b1, 2048, 0, 0, 0));
    cfg_stop();
    b = fill_box(0, 0);
    b.axis[0][0] = 256;
    b.centre[0]  = -256;
    box_q.push_back(b);
    b.centre[0]  = -257;        // one step outside
    box_q.push_back(b);
    b = fill_box(0, 0);
    b.axis[1][0] = -256;
    b.axis[2][0] = 256;
    b.centre[0]  = -512;        // negative half-axis still counts by size
    box_q.push_back(b);
    wait_idle();

    // write past the register list: must change nothing
    cfg_write(REG_NONE, '1);
    cfg_stop();
    b = fill_box(0, 0);
    b.axis[0][0] = 256;
    b.centre[0]  = -257;
    box_q.push_back(b);
    wait_idle();

    // extreme planes
    cfg_write(REG_PLANE_LEFT,   pack_plane(1'b0, -4096, -4096, -4096, 8388607));
    cfg_write(REG_PLANE_RIGHT,  pack_plane(1'b1, 4095, 4095, 4095, -8388608));
    cfg_write(REG_PLANE_TOP,    '1);
    cfg_write(REG_PLANE_BOTTOM, pack_plane(1'b0, 4095, -4096, 0, 8388607));
    cfg_write(REG_PLANE_NEAR,   pack_plane(1'b1, 0, 0, -4096, -8388608));
    cfg_write(REG_PLANE_FAR,    pack_plane(1'b0, 1, -1, 0, 0));
    cfg_stop();
    box_q.push_back(fill_box(0, 0));
    box_q.push_back(fill_box(coord_t'(8388607), coord_t'(8388607)));
    box_q.push_back(fill_box(coord_t'(-8388608), coord_t'(-8388608)));
    box_q.push_back(fill_box(coord_t'(8388607), coord_t'(-8388608)));
    box_q.push_back(fill_box(0, coord_t'(8388607)));
    wait_idle();

    // random phases, each with a fresh frustum
    sent = 0;
    while (sent < RAND_ITEMS) begin
      en = {$urandom, $urandom};
      en[0] = ($urandom_range(0, 4) != 0);
      cfg_write(REG_CULL_EN, en);
      for (int p = 0; p < NUM_PLANES; p++) begin
        cfg_write(CFG_IDX_W'(int'(REG_PLANE_LEFT) + p), rnd_plane());
      end
      if ($urandom_range(0, 2) == 0) cfg_write(REG_NONE, {$urandom, $urandom});
      cfg_stop();
      n = $urandom_range(120, 260);
      for (int i = 0; i < n; i++) box_q.push_back(rnd_box());
      sent += n;
      wait_idle();
    end

    repeat (PIPE_DEPTH) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
